[src/csc_pkg.sv]
package csc_pkg;

	// Width of one set element.
	localparam int VAL_W = 32;

	// Sequencer states of the back end.
	typedef enum logic [1:0] {
		BK_INIT,
		BK_IDLE,
		BK_WALK,
		BK_CLEAR
	} bk_state_t;

	// One closed set as the front end hands it to the back end.
	typedef struct packed {
		logic                    walk;
		logic                    ovf;
		logic signed [VAL_W-1:0] min;
	} set_desc_t;

	localparam int DESC_W = $bits(set_desc_t);

endpackage

[src/csc_front.sv]
module csc_front #(
	parameter int MAX_ITEMS = 1024,
	parameter int AW        = 10,
	parameter int CW        = 11
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [csc_pkg::VAL_W-1:0] value,
	input  logic                         last_item,
	input  logic                         init_done,
	input  logic                         q_full,
	input  logic                         walk_done,
	output logic                         push,
	output csc_pkg::set_desc_t           desc,
	output logic [CW-1:0]                desc_cnt,
	output logic                         st_we,
	output logic [AW-1:0]                st_addr,
	output logic [csc_pkg::VAL_W-1:0]    st_data
);
	import csc_pkg::*;

	logic signed [VAL_W-1:0] min_q;
	logic signed [VAL_W-1:0] max_q;
	logic [CW-1:0]           cnt_q;
	logic                    cap_q;
	logic                    fin_q;
	logic                    lock_q;
	logic                    accept;
	logic                    room;
	logic [VAL_W+1:0]        span;

	assign busy   = !init_done || q_full || lock_q || fin_q;
	assign accept = start && !busy;
	assign room   = cnt_q < CW'(MAX_ITEMS);

	// Element goes straight into the store at the next free slot.
	assign st_we   = accept && room;
	assign st_addr = cnt_q[AW-1:0];
	assign st_data = value;

	// The span is formed in the cycle after the last element, from the registers.
	assign span = {{2{max_q[VAL_W-1]}}, max_q} - {{2{min_q[VAL_W-1]}}, min_q}
		+ (VAL_W+2)'(1);

	assign push          = fin_q;
	assign desc.walk     = !cap_q && (span == (VAL_W+2)'(cnt_q));
	assign desc.ovf      = cap_q;
	assign desc.min      = min_q;
	assign desc_cnt      = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q  <= {1'b0, {(VAL_W-1){1'b1}}};
			max_q  <= {1'b1, {(VAL_W-1){1'b0}}};
			cnt_q  <= '0;
			cap_q  <= 1'b0;
			fin_q  <= 1'b0;
			lock_q <= 1'b0;
		end else begin
			if (fin_q) begin
				min_q <= {1'b0, {(VAL_W-1){1'b1}}};
				max_q <= {1'b1, {(VAL_W-1){1'b0}}};
				cnt_q <= '0;
				cap_q <= 1'b0;
				fin_q <= 1'b0;
			end else if (accept) begin
				if (room) begin
					if (value < min_q) begin
						min_q <= value;
					end
					if (value > max_q) begin
						max_q <= value;
					end
					cnt_q <= cnt_q + CW'(1);
				end else begin
					cap_q <= 1'b1;
				end
				fin_q <= last_item;
			end
			// The store stays locked from the hand-off of a set that needs a
			// walk until the back end has finished reading it.
			if (push && desc.walk) begin
				lock_q <= 1'b1;
			end else if (walk_done) begin
				lock_q <= 1'b0;
			end
		end
	end

endmodule

[src/csc_queue.sv]
module csc_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         empty,
	output logic         full
);
	logic [W-1:0] slot_q [2];
	logic         wp_q;
	logic         rp_q;
	logic [1:0]   n_q;

	assign dout  = slot_q[rp_q];
	assign empty = (n_q == 2'd0);
	assign full  = (n_q == 2'd2);

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			n_q  <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			if (push && !pop) begin
				n_q <= n_q + 2'd1;
			end else if (pop && !push) begin
				n_q <= n_q - 2'd1;
			end
		end
	end

endmodule

[src/csc_back.sv]
module csc_back #(
	parameter int MAX_ITEMS = 1024,
	parameter int AW        = 10,
	parameter int CW        = 11
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      st_we,
	input  logic [AW-1:0]             st_addr,
	input  logic [csc_pkg::VAL_W-1:0] st_data,
	input  logic                      q_empty,
	input  csc_pkg::set_desc_t        q_desc,
	input  logic [CW-1:0]             q_cnt,
	output logic                      pop,
	output logic                      init_done,
	output logic                      walk_done,
	output logic                      done,
	output logic                      consecutive,
	output logic                      overflow
);
	import csc_pkg::*;

	logic [VAL_W-1:0]        store_mem [MAX_ITEMS];
	logic                    vis_mem   [MAX_ITEMS];

	bk_state_t               state_q;
	bk_state_t               state_d;
	logic signed [VAL_W-1:0] min_q;
	logic [CW-1:0]           cnt_q;
	logic [CW-1:0]           iss_q;
	logic [CW-1:0]           clr_q;
	logic                    v_s2;
	logic                    v_s3;
	logic [VAL_W-1:0]        data_s2;
	logic [AW-1:0]           off_s3;
	logic                    inr_s3;
	logic                    vis_s3;
	logic                    wr_v_q;
	logic [AW-1:0]           wr_off_q;
	logic                    done_q;
	logic                    cons_q;
	logic                    ovf_q;

	logic                    issue;
	logic [VAL_W:0]          diff;
	logic                    inr;
	logic                    dup;
	logic                    s3_fail;
	logic                    s3_pass;
	logic                    walk_end;
	logic                    vis_we;
	logic [AW-1:0]           vis_wa;
	logic                    vis_wd;
	logic                    res_fire;
	logic                    res_cons;
	logic                    res_ovf;

	// Walk pipeline: read the element, form its offset and read the map,
	// then test and mark. A mark made in the previous cycle is forwarded.
	assign issue = (state_q == BK_WALK) && (iss_q != cnt_q);
	assign diff  = {data_s2[VAL_W-1], data_s2} - {min_q[VAL_W-1], min_q};
	assign inr   = !diff[VAL_W] && (diff < (VAL_W+1)'(MAX_ITEMS));
	assign dup   = vis_s3 || (wr_v_q && (wr_off_q == off_s3));
	assign s3_fail = v_s3 && (!inr_s3 || dup);
	assign s3_pass = v_s3 && inr_s3 && !dup;
	assign walk_end = (state_q == BK_WALK) && (s3_fail || (!issue && !v_s2 && !v_s3));

	always_ff @(posedge clk) begin
		if (st_we) begin
			store_mem[st_addr] <= st_data;
		end
		if (issue) begin
			data_s2 <= store_mem[iss_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (vis_we) begin
			vis_mem[vis_wa] <= vis_wd;
		end
		if (v_s2) begin
			vis_s3 <= vis_mem[diff[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		off_s3   <= diff[AW-1:0];
		inr_s3   <= inr;
		wr_off_q <= off_s3;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_INIT: begin
				if (clr_q == CW'(MAX_ITEMS - 1)) begin
					state_d = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (!q_empty && q_desc.walk) begin
					state_d = BK_WALK;
				end
			end
			BK_WALK: begin
				if (walk_end) begin
					state_d = BK_CLEAR;
				end
			end
			BK_CLEAR: begin
				if (clr_q == cnt_q - CW'(1)) begin
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_INIT;
			end
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		vis_we   = 1'b0;
		vis_wa   = clr_q[AW-1:0];
		vis_wd   = 1'b0;
		res_fire = 1'b0;
		res_cons = 1'b0;
		res_ovf  = 1'b0;
		case (state_q)
			BK_INIT, BK_CLEAR: begin
				vis_we = 1'b1;
			end
			BK_IDLE: begin
				pop = !q_empty;
				if (!q_empty && !q_desc.walk) begin
					res_fire = 1'b1;
					res_ovf  = q_desc.ovf;
				end
			end
			BK_WALK: begin
				if (s3_pass) begin
					vis_we = 1'b1;
					vis_wa = off_s3;
					vis_wd = 1'b1;
				end
				if (walk_end) begin
					res_fire = 1'b1;
					res_cons = !s3_fail;
				end
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	assign init_done   = (state_q != BK_INIT);
	assign walk_done   = walk_end;
	assign done        = done_q;
	assign consecutive = cons_q;
	assign overflow    = ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_INIT;
			min_q   <= '0;
			cnt_q   <= '0;
			iss_q   <= '0;
			clr_q   <= '0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			wr_v_q  <= 1'b0;
			done_q  <= 1'b0;
			cons_q  <= 1'b0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop) begin
				min_q <= q_desc.min;
				cnt_q <= q_cnt;
				iss_q <= '0;
			end else if (issue) begin
				iss_q <= iss_q + CW'(1);
			end
			if (walk_end) begin
				clr_q <= '0;
			end else if ((state_q == BK_INIT) || (state_q == BK_CLEAR)) begin
				clr_q <= clr_q + CW'(1);
			end
			v_s2   <= issue && !walk_end;
			v_s3   <= v_s2 && !walk_end;
			wr_v_q <= s3_pass;
			done_q <= res_fire;
			cons_q <= res_cons;
			ovf_q  <= res_ovf;
		end
	end

endmodule

[src/consecutive_set_checker.sv]
// Channel   Handshake        Payload                 Meaning
// request   start / busy     value, last_item        one set element, last marks set end
// result    done (strobe)    consecutive, overflow   one answer per set, held one cycle
//
// Elements load at one per cycle while busy is low; the cycle after a last element closes the set.
// A set that passes the span test is then walked against the visited map,
// after which the map entries it used are cleared.
// After reset a clearing pass runs over all MAX_ITEMS entries of the visited map and
// busy stays high; a new set may load while the map clears behind the last one.
// The receiver cannot stall: done is a single-cycle strobe.
module consecutive_set_checker #(
	parameter int MAX_ITEMS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] value,
	input  logic        last_item,
	output logic        done,
	output logic        consecutive,
	output logic        overflow
);
	import csc_pkg::*;

	localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int QW = DESC_W + CW;

	// Front end to store and queue.
	logic             push;
	set_desc_t        f_desc;
	logic [CW-1:0]    f_cnt;
	logic             st_we;
	logic [AW-1:0]    st_addr;
	logic [VAL_W-1:0] st_data;

	// Queue to back end.
	logic             q_full;
	logic             q_empty;
	logic             pop;
	logic [QW-1:0]    q_dout;
	set_desc_t        b_desc;
	logic [CW-1:0]    b_cnt;

	// Back end status toward the front end.
	logic             init_done;
	logic             walk_done;

	// The front end tracks min, max and count while writing the store, and
	// closes each set into a descriptor; sets that fail the span test or
	// overflowed need no walk and are answered straight from the queue.
	csc_front #(
		.MAX_ITEMS (MAX_ITEMS),
		.AW        (AW),
		.CW        (CW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.value     ($signed(value)),
		.last_item (last_item),
		.init_done (init_done),
		.q_full    (q_full),
		.walk_done (walk_done),
		.push      (push),
		.desc      (f_desc),
		.desc_cnt  (f_cnt),
		.st_we     (st_we),
		.st_addr   (st_addr),
		.st_data   (st_data)
	);

	// A two-entry queue keeps answers in set order while the back end works.
	csc_queue #(
		.W (QW)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    ({f_desc, f_cnt}),
		.pop    (pop),
		.dout   (q_dout),
		.empty  (q_empty),
		.full   (q_full)
	);

	assign b_desc = set_desc_t'(q_dout[QW-1:CW]);
	assign b_cnt  = q_dout[CW-1:0];

	// The back end owns the element store and the visited map, runs the
	// duplicate walk and registers every answer.
	csc_back #(
		.MAX_ITEMS (MAX_ITEMS),
		.AW        (AW),
		.CW        (CW)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.st_we       (st_we),
		.st_addr     (st_addr),
		.st_data     (st_data),
		.q_empty     (q_empty),
		.q_desc      (b_desc),
		.q_cnt       (b_cnt),
		.pop         (pop),
		.init_done   (init_done),
		.walk_done   (walk_done),
		.done        (done),
		.consecutive (consecutive),
		.overflow    (overflow)
	);

endmodule

[bench/consecutive_set_checker_tb.sv]
`timescale 1ns / 1ps

// Self-checking bench for the consecutive set checker.
//
// Sets of signed words are fed to the block one request at a time, the last
// request of each set carrying last_item. A predictor in this module folds
// every accepted request into its own copy of the set state (stored words,
// running minimum and maximum, element count, spill flag). When a set closes,
// the predictor decides the answer and pushes it onto a queue. Every done
// strobe is compared against the oldest answer on that queue.
//
// The run starts with a short table of hand-picked sets. These cover the
// word extremes, a sign crossing, a gap, and duplicates both with and without
// a matching span. A long stretch of random sets follows. Most of these
// are shuffled runs, some with a duplicate or a gap planted in them, and the
// rest is noise.
module consecutive_set_checker_tb;

	localparam int          CAP          = 1024;
	localparam int          RANDOM_ITEMS = 927;
	localparam int unsigned LIMIT_CYCLES = 400000;

	localparam logic [31:0] WORD_MIN = 32'h8000_0000;
	localparam logic [31:0] WORD_MAX = 32'h7FFF_FFFF;

	typedef logic [csc_pkg::VAL_W-1:0] word_t;
	typedef word_t word_q_t[$];

	// One answer as the block reports it.
	typedef struct packed {
		logic consecutive;
		logic overflow;
	} verdict_t;

	// One row of the directed table. When typed is set, the answer in the row
	// is what the set must give, and the predictor's opinion is not used.
	typedef struct packed {
		word_t value;
		logic  last;
		logic  typed;
		logic  consec;
		logic  ovf;
	} stim_row_t;

	localparam int DIR_ROWS = 23;

	stim_row_t dir_rows [DIR_ROWS] = '{
		// Single element sets at both ends of the range are runs of one.
		'{WORD_MIN,       1'b1, 1'b1, 1'b1, 1'b0},
		'{WORD_MAX,       1'b1, 1'b1, 1'b1, 1'b0},
		// Both extremes together: the span is 2**32 and must not wrap.
		'{WORD_MAX,       1'b0, 1'b0, 1'b0, 1'b0},
		'{WORD_MIN,       1'b1, 1'b1, 1'b0, 1'b0},
		// A plain ascending run.
		'{32'd0,          1'b0, 1'b0, 1'b0, 1'b0},
		'{32'd1,          1'b0, 1'b0, 1'b0, 1'b0},
		'{32'd2,          1'b1, 1'b1, 1'b1, 1'b0},
		// The span matches the count, but one value repeats.
		'{32'd1,          1'b0, 1'b0, 1'b0, 1'b0},
		'{32'd2,          1'b0, 1'b0, 1'b0, 1'b0},
		'{32'd2,          1'b0, 1'b0, 1'b0, 1'b0},
		'{32'd4,          1'b1, 1'b1, 1'b0, 1'b0},
		// Pairs hugging the top and the bottom of the range.
		'{32'h7FFF_FFFE,  1'b0, 1'b0, 1'b0, 1'b0},
		'{WORD_MAX,       1'b1, 1'b1, 1'b1, 1'b0},
		'{32'h8000_0001,  1'b0, 1'b0, 1'b0, 1'b0},
		'{WORD_MIN,       1'b1, 1'b1, 1'b1, 1'b0},
		// A run that crosses zero.
		'{32'hFFFF_FFFF,  1'b0, 1'b0, 1'b0, 1'b0},
		'{32'd0,          1'b1, 1'b1, 1'b1, 1'b0},
		// A gap in the middle.
		'{32'd3,          1'b0, 1'b0, 1'b0, 1'b0},
		'{32'd1,          1'b1, 1'b1, 1'b0, 1'b0},
		// A plain duplicate, so the span is short of the count.
		'{32'd5,          1'b0, 1'b0, 1'b0, 1'b0},
		'{32'd5,          1'b1, 1'b1, 1'b0, 1'b0},
		// Alternating bit patterns, left to the predictor.
		'{32'hAAAA_AAAA,  1'b0, 1'b0, 1'b0, 1'b0},
		'{32'h5555_5555,  1'b1, 1'b0, 1'b0, 1'b0}
	};

	logic  clk;
	logic  arst_n    = 1'b0;
	logic  start     = 1'b0;
	logic  busy;
	word_t value     = '0;
	logic  last_item = 1'b0;
	logic  done;
	logic  consecutive;
	logic  overflow;

	consecutive_set_checker #(
		.MAX_ITEMS(CAP)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.value      (value),
		.last_item  (last_item),
		.done       (done),
		.consecutive(consecutive),
		.overflow   (overflow)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// The predictor's copy of the set that is currently loading.
	word_t              set_values [CAP];
	logic signed [31:0] set_min     = WORD_MAX;
	logic signed [31:0] set_max     = WORD_MIN;
	int unsigned        set_count   = 0;
	bit                 set_spilled = 1'b0;

	// Answers owed by the block, oldest first.
	verdict_t pending_verdicts[$];

	int unsigned mismatch_count = 0;
	int unsigned cycle_count    = 0;

	task automatic flag_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// The span test and the duplicate walk on the set held by the predictor.
	// The walk only looks at words written in this set.
	function automatic bit set_is_run();
		bit     seen [CAP];
		longint span;
		longint off;
		if (set_count == 0)
			return 1'b0;
		span = longint'(set_max) - longint'(set_min) + 1;
		if (span != longint'(set_count))
			return 1'b0;
		for (int i = 0; i < set_count; i++) begin
			off = longint'($signed(set_values[i])) - longint'(set_min);
			if (off < 0 || off >= CAP)
				return 1'b0;
			if (seen[off])
				return 1'b0;
			seen[off] = 1'b1;
		end
		return 1'b1;
	endfunction

	// Folds one accepted request into the set. When the request closes the set,
	// the answer is returned and the set state goes back to its reset values.
	// The stored words are left as they are.
	function automatic void fold_element(input word_t v, input logic l,
			output bit closed, output verdict_t verdict);
		closed  = 1'b0;
		verdict = '0;
		if (set_count < CAP) begin
			set_values[set_count] = v;
			if ($signed(v) < set_min)
				set_min = v;
			if ($signed(v) > set_max)
				set_max = v;
			set_count++;
		end else begin
			// The store is full: the word is dropped and the set is marked.
			set_spilled = 1'b1;
		end
		if (!l)
			return;
		closed = 1'b1;
		if (set_spilled)
			verdict.overflow = 1'b1;
		else
			verdict.consecutive = set_is_run();
		set_min     = WORD_MAX;
		set_max     = WORD_MIN;
		set_count   = 0;
		set_spilled = 1'b0;
	endfunction

	// Presents one request after an idle gap and waits for the block to take
	// it. With no gap, start stays high from the previous request, so start is
	// assigned only once in that time step.
	task automatic send_item(input word_t v, input logic l, input int gap,
			input bit typed, input verdict_t typed_verdict);
		bit       closed;
		verdict_t verdict;
		if (gap > 0) begin
			start     <= 1'b0;
			value     <= $urandom;
			last_item <= $urandom_range(0, 1);
			repeat (gap) @(posedge clk);
		end
		start     <= 1'b1;
		value     <= v;
		last_item <= l;
		// busy read right after the edge is the value the block held during
		// the cycle that edge closes, which is what the handshake looks at.
		do
			@(posedge clk);
		while (busy);
		fold_element(v, l, closed, verdict);
		if (closed)
			pending_verdicts.push_back(typed ? typed_verdict : verdict);
	endtask

	// Sends a whole set, the last word flagged. A burst set has no gaps at all.
	task automatic send_set(input word_q_t vals, input bit burst);
		for (int i = 0; i < vals.size(); i++)
			send_item(vals[i], i == vals.size() - 1,
				burst ? 0 : $urandom_range(0, 14), 1'b0, '0);
	endtask

	// A shuffled run of n distinct consecutive words. The base sometimes sits
	// right at the bottom or the top of the signed range.
	function automatic word_q_t make_run(input int n);
		word_q_t vals;
		longint  base;
		word_t   tmp;
		int      j;
		case ($urandom_range(0, 3))
			0: base = -longint'(2147483647) - 1 + $urandom_range(0, 3);
			1: base = longint'(2147483647) - n + 1 - $urandom_range(0, 3);
			default: base = longint'($signed($urandom));
		endcase
		if (base + n - 1 > longint'(2147483647))
			base = longint'(2147483647) - n + 1;
		for (int i = 0; i < n; i++)
			vals.push_back(word_t'(base + i));
		for (int i = n - 1; i > 0; i--) begin
			j       = $urandom_range(0, i);
			tmp     = vals[i];
			vals[i] = vals[j];
			vals[j] = tmp;
		end
		return vals;
	endfunction

	// Every result strobe must match the oldest answer owed, field by field.
	always @(posedge clk) begin : result_check
		verdict_t want;
		if (arst_n && done) begin
			if (pending_verdicts.size() == 0) begin
				flag_mismatch("result strobe while no set was closed");
			end else begin
				want = pending_verdicts.pop_front();
				if (consecutive !== want.consecutive)
					flag_mismatch($sformatf("consecutive is %b, expected %b",
						consecutive, want.consecutive));
				if (overflow !== want.overflow)
					flag_mismatch($sformatf("overflow is %b, expected %b",
						overflow, want.overflow));
			end
		end
	end

	// Watchdog: a hung handshake or a missing result ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin : stimulus
		word_q_t  vals;
		verdict_t row_verdict;
		int       random_items;
		int       n;
		int       kind;
		int       i;
		int       j;
		bit       burst;

		random_items = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed table. The block's clearing pass after reset keeps busy
		// high for a while, so the first request simply waits it out.
		foreach (dir_rows[r]) begin
			row_verdict.consecutive = dir_rows[r].consec;
			row_verdict.overflow    = dir_rows[r].ovf;
			send_item(dir_rows[r].value, dir_rows[r].last,
				$urandom_range(0, 14), dir_rows[r].typed, row_verdict);
		end

		// Random sets. Most are runs, since only sets whose span matches the count
		// get past the span test into the duplicate walk. Sizes stay small, with an
		// occasional medium set.
		while (random_items < RANDOM_ITEMS) begin
			n     = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
				: $urandom_range(1, 12);
			kind  = $urandom_range(0, 19);
			burst = ($urandom_range(0, 3) == 0);
			if (kind < 10) begin
				vals = make_run(n);
			end else if (kind < 14) begin
				// A run with one word copied over another: a duplicate,
				// which sometimes also shortens the span.
				vals = make_run(n);
				if (n > 1) begin
					i       = $urandom_range(0, n - 1);
					j       = (i + $urandom_range(1, n - 1)) % n;
					vals[i] = vals[j];
				end
			end else if (kind < 17) begin
				// A run with one word pushed out, which opens a gap.
				vals    = make_run(n);
				i       = $urandom_range(0, n - 1);
				vals[i] = vals[i] + n;
			end else begin
				// Noise: either wide random words, or words packed into a
				// tiny window so that accidental runs and repeats show up.
				vals.delete();
				for (int k = 0; k < n; k++)
					vals.push_back($urandom_range(0, 1) ? $urandom
						: $urandom_range(0, 7) - 4);
			end
			send_set(vals, burst);
			random_items += vals.size();
		end

		start <= 1'b0;

		// Wait for every answer owed, then let the last walk and the clear
		// behind it run out.
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (2 * CAP + 16) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
